@@ sv/gcd_pkg.sv @@
`default_nettype none

package gcd_pkg;

    // List sizing.
    localparam int MAX_LINKS = 256;
    localparam int ADDR_W    = $clog2(MAX_LINKS);
    localparam int CNT_W     = $clog2(MAX_LINKS + 1);
    localparam int MISM_W    = $clog2(2 * MAX_LINKS + 1);

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int INNOV_W    = 16;
    localparam int WEIGHT_W   = 32;
    localparam int COEFF_W    = 16;
    localparam int DIST_W     = 48;
    localparam int MISM_OUT_W = 10;
    localparam int CFG_IDX_W  = 1;

    // Datapath widths of the merge and the final scaling.
    localparam int ABS_W   = WEIGHT_W + 1;
    localparam int WSUM_W  = WEIGHT_W + CNT_W;
    localparam int WHI_W   = WSUM_W - WEIGHT_W;
    localparam int PA_W    = COEFF_W + WEIGHT_W;
    localparam int PB_W    = COEFF_W + WHI_W;
    localparam int PG_W    = COEFF_W + MISM_W;
    localparam int ACC_W   = PA_W + 1;
    localparam int TOT_RAW = PA_W + WHI_W + 1;
    localparam int TOT_W   = (TOT_RAW > DIST_W + 9) ? TOT_RAW : DIST_W + 9;

    // Front-to-back queue depth.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Command codes on the input port.
    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GENE_COEFF   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_COEFF = 1'b1;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd256;

    // Operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_LOAD_A,
        OP_LOAD_B,
        OP_COMPUTE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [INNOV_W-1:0]  innov;
        logic [WEIGHT_W-1:0] weight;
    } q_item_t;

    typedef struct packed {
        logic [INNOV_W-1:0]  innov;
        logic [WEIGHT_W-1:0] weight;
    } link_t;

    typedef struct packed {
        logic [COEFF_W-1:0] gene;
        logic [COEFF_W-1:0] weight;
    } coeff_t;

    typedef struct packed {
        logic [DIST_W-1:0]     distance;
        logic [MISM_OUT_W-1:0] mismatches;
        logic                  overflowed;
    } res_t;

    // Clamp the mismatch count to the width of the result field.
    function automatic logic [MISM_OUT_W-1:0] sat_mism(input logic [MISM_W-1:0] m);
        logic [MISM_W+MISM_OUT_W-1:0] ext;
        ext = {{MISM_OUT_W{1'b0}}, m};
        if (ext > (MISM_W + MISM_OUT_W)'((1 << MISM_OUT_W) - 1))
        begin
            return '1;
        end
        return ext[MISM_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/genome_compatibility_distance_top.sv @@
`default_nettype none

// Channel   Handshake             Payload
// input     push / full           cmd, link_innov, link_weight
// result    empty / pop           distance, mismatches, overflowed
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Loads stream at one per cycle while the back end has no compute running.
// A compute merges both lists in a series of steps; a step
// consumes one link or a matched pair, so steps <= first_count + second_count.
// Reset empties both lists and the queues and sets both coefficients to 256.
// A four-entry queue decouples decoder and back end; a finished compute
// waits in the back end while the single result register is still full.
module genome_compatibility_distance_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [gcd_pkg::CMD_W-1:0]       cmd,
    input  wire logic [gcd_pkg::INNOV_W-1:0]     link_innov,
    input  wire logic [gcd_pkg::WEIGHT_W-1:0]    link_weight,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [gcd_pkg::DIST_W-1:0]           distance,
    output logic [gcd_pkg::MISM_OUT_W-1:0]       mismatches,
    output logic                                 overflowed,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gcd_pkg::COEFF_W-1:0]     cfg_data
);
    import gcd_pkg::*;

    coeff_t   coeff_reg, coeff_next;
    logic     q_valid;
    q_item_t  q_item;
    logic     q_pop;
    logic     res_valid;
    res_t     res;

    // Coefficient registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GENE_COEFF:   coeff_next.gene   = cfg_data;
                CFG_WEIGHT_COEFF: coeff_next.weight = cfg_data;
                default:          coeff_next        = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '{gene: COEFF_RESET, weight: COEFF_RESET};
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    // Decoder and item queue.
    gcd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .link_innov  (link_innov),
        .link_weight (link_weight),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // List storage, merge and scaling.
    gcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .coeff     (coeff_reg),
        .res_pop   (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty      = !res_valid;
    assign distance   = res.distance;
    assign mismatches = res.mismatches;
    assign overflowed = res.overflowed;

endmodule

`default_nettype wire

@@ sv/gcd_front.sv @@
`default_nettype none

module gcd_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [gcd_pkg::CMD_W-1:0]    cmd,
    input  wire logic [gcd_pkg::INNOV_W-1:0]  link_innov,
    input  wire logic [gcd_pkg::WEIGHT_W-1:0] link_weight,
    output logic                              q_valid,
    output gcd_pkg::q_item_t                  q_item,
    input  wire logic                         q_pop
);
    import gcd_pkg::*;

    q_item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                keep;
    op_t                 op;
    logic                do_push;
    logic                do_pop;

    // Decode the command; the unused code is dropped here.
    always_comb
    begin
        keep = 1'b1;
        op   = OP_COMPUTE;
        unique case (cmd)
            CMD_LOAD_FIRST:  op = OP_LOAD_A;
            CMD_LOAD_SECOND: op = OP_LOAD_B;
            CMD_COMPUTE:     op = OP_COMPUTE;
            default:         keep = 1'b0;
        endcase
    end

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full && keep;
    assign do_pop  = q_pop && q_valid;

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= '{op: op, innov: link_innov, weight: link_weight};
        end
    end

endmodule

`default_nettype wire

@@ sv/gcd_back.sv @@
`default_nettype none

module gcd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire gcd_pkg::q_item_t q_item,
    output logic                  q_pop,
    input  wire gcd_pkg::coeff_t  coeff,
    input  wire logic             res_pop,
    output logic                  res_valid,
    output gcd_pkg::res_t         res
);
    import gcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_STEP,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]    cnt_b_reg, cnt_b_next;
    logic                ovf_reg, ovf_next;
    logic                ovf_out_reg, ovf_out_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [MISM_W-1:0]   mism_reg, mism_next;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [ABS_W-1:0]    add_reg, add_next;
    logic [PA_W-1:0]     prod_a_reg, prod_a_next;
    logic [PB_W-1:0]     prod_b_reg, prod_b_next;
    logic [PG_W-1:0]     prod_g_reg, prod_g_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    link_t               mem_a [MAX_LINKS];
    link_t               mem_b [MAX_LINKS];
    link_t               rd_a_reg;
    link_t               rd_b_reg;
    logic                wr_a;
    logic                wr_b;

    logic                a_left;
    logic                b_left;
    logic                w_ge;
    logic [ABS_W-1:0]    w_diff;
    logic                sat;

    // Step compare: absolute weight difference of the two heads.
    assign a_left = (i_reg < cnt_a_reg);
    assign b_left = (j_reg < cnt_b_reg);
    assign w_ge   = ($signed(rd_a_reg.weight) >= $signed(rd_b_reg.weight));
    assign w_diff = w_ge
        ? {rd_a_reg.weight[WEIGHT_W-1], rd_a_reg.weight}
          - {rd_b_reg.weight[WEIGHT_W-1], rd_b_reg.weight}
        : {rd_b_reg.weight[WEIGHT_W-1], rd_b_reg.weight}
          - {rd_a_reg.weight[WEIGHT_W-1], rd_a_reg.weight};

    assign sat = |total_reg[TOT_W-1:DIST_W+8];

    // Sequencer for loads, the merge walk and the scaling.
    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ovf_next       = ovf_reg;
        ovf_out_next   = ovf_out_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        mism_next      = mism_reg;
        wsum_next      = wsum_reg;
        add_next       = add_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        prod_g_next    = prod_g_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        wr_a           = 1'b0;
        wr_b           = 1'b0;

        if (res_pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.op)
                        OP_LOAD_A:
                        begin
                            if (cnt_a_reg == CNT_W'(MAX_LINKS))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + CNT_W'(1);
                            end
                        end
                        OP_LOAD_B:
                        begin
                            if (cnt_b_reg == CNT_W'(MAX_LINKS))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + CNT_W'(1);
                            end
                        end
                        OP_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            mism_next  = '0;
                            wsum_next  = '0;
                            add_next   = '0;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Fold in the last match while the memories fetch both heads.
            S_READ:
            begin
                wsum_next = wsum_reg + WSUM_W'(add_reg);
                add_next  = '0;
                if (a_left || b_left)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end

            S_STEP:
            begin
                state_next = S_READ;
                if (!a_left)
                begin
                    mism_next = mism_reg + MISM_W'(1);
                    j_next    = j_reg + CNT_W'(1);
                end
                else if (!b_left)
                begin
                    mism_next = mism_reg + MISM_W'(1);
                    i_next    = i_reg + CNT_W'(1);
                end
                else if (rd_a_reg.innov < rd_b_reg.innov)
                begin
                    mism_next = mism_reg + MISM_W'(1);
                    i_next    = i_reg + CNT_W'(1);
                end
                else if (rd_a_reg.innov > rd_b_reg.innov)
                begin
                    mism_next = mism_reg + MISM_W'(1);
                    j_next    = j_reg + CNT_W'(1);
                end
                else
                begin
                    add_next = w_diff;
                    i_next   = i_reg + CNT_W'(1);
                    j_next   = j_reg + CNT_W'(1);
                end
            end

            // Low partial product and gene term; the lists are emptied here.
            S_MUL1:
            begin
                prod_a_next  = PA_W'(coeff.weight) * PA_W'(wsum_reg[WEIGHT_W-1:0]);
                prod_g_next  = PG_W'(coeff.gene) * PG_W'(mism_reg);
                ovf_out_next = ovf_reg;
                ovf_next     = 1'b0;
                cnt_a_next   = '0;
                cnt_b_next   = '0;
                state_next   = S_MUL2;
            end

            S_MUL2:
            begin
                prod_b_next = PB_W'(coeff.weight) * PB_W'(wsum_reg[WSUM_W-1:WEIGHT_W]);
                acc_next    = ACC_W'(prod_a_reg) + (ACC_W'(prod_g_reg) << 16);
                state_next  = S_MUL3;
            end

            S_MUL3:
            begin
                total_next = TOT_W'(acc_reg) + (TOT_W'(prod_b_reg) << WEIGHT_W);
                state_next = S_DONE;
            end

            // Drop the extra fraction bits, saturate and hand over the result.
            S_DONE:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    res_valid_next      = 1'b1;
                    res_next.distance   = sat ? '1 : total_reg[DIST_W+7:8];
                    res_next.mismatches = sat_mism(mism_reg);
                    res_next.overflowed = ovf_out_reg;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ovf_out_reg <= ovf_out_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        mism_reg    <= mism_next;
        wsum_reg    <= wsum_next;
        add_reg     <= add_next;
        prod_a_reg  <= prod_a_next;
        prod_b_reg  <= prod_b_next;
        prod_g_reg  <= prod_g_next;
        acc_reg     <= acc_next;
        total_reg   <= total_next;
        res_reg     <= res_next;
    end

    // First list memory.
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cnt_a_reg[ADDR_W-1:0]] <= '{innov: q_item.innov, weight: q_item.weight};
        end
        rd_a_reg <= mem_a[i_reg[ADDR_W-1:0]];
    end

    // Second list memory.
    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[cnt_b_reg[ADDR_W-1:0]] <= '{innov: q_item.innov, weight: q_item.weight};
        end
        rd_b_reg <= mem_b[j_reg[ADDR_W-1:0]];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ tb/genome_compatibility_distance_top_tb.sv @@
`timescale 1ns / 100ps

module genome_compatibility_distance_top_tb;

    import gcd_pkg::*;

    // The one command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_RESULT = 20;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 64;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASE_ITEMS    = 35;
    localparam int REPORT_MAX     = 10;

    localparam logic [63:0] DIST_CEIL = (64'd1 << DIST_W) - 64'd1;

    typedef struct packed {
        logic [CMD_W-1:0]    op;
        logic [INNOV_W-1:0]  innov;
        logic [WEIGHT_W-1:0] weight;
        logic                fixed;
        res_t                want;
    } step_row_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  push        = 1'b0;
    logic [CMD_W-1:0]      cmd         = '0;
    logic [INNOV_W-1:0]    link_innov  = '0;
    logic [WEIGHT_W-1:0]   link_weight = '0;
    logic                  pop         = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [COEFF_W-1:0]    cfg_data    = '0;
    logic                  full;
    logic                  empty;
    logic                  cfg_ready;
    logic [DIST_W-1:0]     distance;
    logic [MISM_OUT_W-1:0] mismatches;
    logic                  overflowed;

    // Software copy of both link lists and the coefficients.
    logic [INNOV_W-1:0]  list1_innov  [MAX_LINKS];
    logic [WEIGHT_W-1:0] list1_weight [MAX_LINKS];
    logic [INNOV_W-1:0]  list2_innov  [MAX_LINKS];
    logic [WEIGHT_W-1:0] list2_weight [MAX_LINKS];
    int unsigned         list1_len = 0;
    int unsigned         list2_len = 0;
    bit                  drop_seen = 1'b0;
    logic [COEFF_W-1:0]  gene_coeff_q   = COEFF_RESET;
    logic [COEFF_W-1:0]  weight_coeff_q = COEFF_RESET;

    res_t      pending_distances [$];
    step_row_t plan [$];
    link_t     first_links [$];
    link_t     second_links [$];

    bit steady_sender    = 1'b0;
    int items_sent       = 0;
    int results_taken    = 0;
    int overflow_results = 0;
    int deepest_mism     = 0;
    int settings_used    = 1;
    int mismatch_count   = 0;
    int quiet_cycles     = 0;

    genome_compatibility_distance_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .link_innov (link_innov),
        .link_weight(link_weight),
        .empty      (empty),
        .pop        (pop),
        .distance   (distance),
        .mismatches (mismatches),
        .overflowed (overflowed),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Weights lean toward the extremes and toward small Q16.16 values.
    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
            default: return $urandom;
        endcase
    endfunction

    // Apply one item to the list copy; a compute merges both lists and clears them.
    task automatic compatibility_step(input logic [CMD_W-1:0] op,
                                      input logic [INNOV_W-1:0] innov,
                                      input logic [WEIGHT_W-1:0] weight,
                                      output bit produced, output res_t res);
        int unsigned i;
        int unsigned j;
        int unsigned mism;
        longint      diff;
        logic [63:0] wsum;
        logic [63:0] total;
        produced = 1'b0;
        res = '0;
        i = 0;
        j = 0;
        mism = 0;
        wsum = '0;
        if (op == CMD_LOAD_FIRST)
        begin
            if (list1_len >= MAX_LINKS)
                drop_seen = 1'b1;
            else
            begin
                list1_innov[list1_len] = innov;
                list1_weight[list1_len] = weight;
                list1_len++;
            end
        end
        else if (op == CMD_LOAD_SECOND)
        begin
            if (list2_len >= MAX_LINKS)
                drop_seen = 1'b1;
            else
            begin
                list2_innov[list2_len] = innov;
                list2_weight[list2_len] = weight;
                list2_len++;
            end
        end
        else if (op == CMD_COMPUTE)
        begin
            // Smaller innovation counts as unmatched; equal ones add |w1 - w2|.
            while (i < list1_len || j < list2_len)
            begin
                if (i >= list1_len)
                begin
                    mism++;
                    j++;
                end
                else if (j >= list2_len)
                begin
                    mism++;
                    i++;
                end
                else if (list1_innov[i] < list2_innov[j])
                begin
                    mism++;
                    i++;
                end
                else if (list1_innov[i] > list2_innov[j])
                begin
                    mism++;
                    j++;
                end
                else
                begin
                    diff = longint'($signed(list1_weight[i]))
                         - longint'($signed(list2_weight[j]));
                    if (diff < 0)
                        diff = -diff;
                    wsum += 64'(diff);
                    i++;
                    j++;
                end
            end
            // Both terms in Q40.24, then truncate to Q32.16 and saturate.
            total = 64'(weight_coeff_q) * wsum
                  + ((64'(gene_coeff_q) * 64'(mism)) << 16);
            total = total >> 8;
            if (total > DIST_CEIL)
                total = DIST_CEIL;
            res.distance = total[DIST_W-1:0];
            res.mismatches = (mism >= (1 << MISM_OUT_W)) ? {MISM_OUT_W{1'b1}}
                                                         : MISM_OUT_W'(mism);
            res.overflowed = drop_seen;
            produced = 1'b1;
            if (int'(mism) > deepest_mism)
                deepest_mism = int'(mism);
            list1_len = 0;
            list2_len = 0;
            drop_seen = 1'b0;
        end
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [INNOV_W-1:0] innov,
                             input logic [WEIGHT_W-1:0] weight, input bit typed,
                             input res_t typed_res);
        int   gap;
        bit   produced;
        res_t res;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        cmd <= op;
        link_innov <= innov;
        link_weight <= weight;
        do @(posedge clk); while (full !== 1'b0);
        compatibility_step(op, innov, weight, produced, res);
        if (op != CMD_UNUSED)
            items_sent++;
        if (produced)
        begin
            if (res.overflowed)
                overflow_results++;
            pending_distances.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic add_row(input logic [CMD_W-1:0] op, input logic [INNOV_W-1:0] innov,
                           input logic [WEIGHT_W-1:0] weight, input bit fixed,
                           input logic [DIST_W-1:0] want_dist,
                           input logic [MISM_OUT_W-1:0] mism);
        step_row_t row;
        row.op = op;
        row.innov = innov;
        row.weight = weight;
        row.fixed = fixed;
        row.want.distance = want_dist;
        row.want.mismatches = mism;
        row.want.overflowed = 1'b0;
        plan.push_back(row);
    endtask

    // Coefficients change only once the block has drained.
    task automatic write_coeffs(input logic [COEFF_W-1:0] gene, input logic [COEFF_W-1:0] wgt);
        push <= 1'b0;
        while (pending_distances.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_GENE_COEFF;
        cfg_data <= gene;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        gene_coeff_q = gene;
        cfg_index <= CFG_WEIGHT_COEFF;
        cfg_data <= wgt;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        weight_coeff_q = wgt;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // A small genome pair: usually sorted with shared innovations, sometimes scrambled.
    task automatic build_genome();
        int                 pool;
        int                 r;
        int                 k;
        logic [INNOV_W-1:0] innov;
        link_t              l;
        pool = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0)
        begin
            for (k = 0; k < pool; k++)
            begin
                l.innov = INNOV_W'($urandom_range(0, 7));
                l.weight = rand_weight();
                if ($urandom_range(0, 1) == 1)
                    first_links.push_back(l);
                else
                    second_links.push_back(l);
            end
        end
        else
        begin
            innov = INNOV_W'($urandom_range(0, 65535 - 3 * pool));
            for (k = 0; k < pool; k++)
            begin
                l.innov = innov;
                r = $urandom_range(0, 2);
                if (r != 1)
                begin
                    l.weight = rand_weight();
                    first_links.push_back(l);
                end
                if (r != 0)
                begin
                    l.weight = rand_weight();
                    second_links.push_back(l);
                end
                innov += INNOV_W'($urandom_range(1, 3));
            end
        end
    endtask

    // Fill the first list past its end with extreme weights; every sixth link also matches.
    task automatic build_large_genome();
        int    k;
        int    base;
        link_t l;
        base = $urandom_range(0, 65535 - 2 * (MAX_LINKS + 2));
        for (k = 0; k < MAX_LINKS + 2; k++)
        begin
            l.innov = INNOV_W'(base + 2 * k);
            l.weight = 32'h7FFF_FFFF;
            first_links.push_back(l);
            if (k % 6 == 0)
            begin
                l.weight = 32'h8000_0000;
                second_links.push_back(l);
            end
        end
    endtask

    // Load both lists in a random interleave with the odd ignored item, then compute.
    task automatic send_genome();
        link_t l;
        bit    pick_first;
        steady_sender = ($urandom_range(0, 4) == 0);
        while (first_links.size() != 0 || second_links.size() != 0)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_UNUSED, INNOV_W'($urandom), $urandom, 1'b0, '0);
            if (first_links.size() == 0)
                pick_first = 1'b0;
            else if (second_links.size() == 0)
                pick_first = 1'b1;
            else
                pick_first = $urandom_range(0, 1);
            if (pick_first)
            begin
                l = first_links.pop_front();
                send_item(CMD_LOAD_FIRST, l.innov, l.weight, 1'b0, '0);
            end
            else
            begin
                l = second_links.pop_front();
                send_item(CMD_LOAD_SECOND, l.innov, l.weight, 1'b0, '0);
            end
        end
        send_item(CMD_COMPUTE, INNOV_W'($urandom), $urandom, 1'b0, '0);
    endtask

    task automatic run_phase(input bit with_large);
        int start_items;
        start_items = items_sent;
        if (with_large)
        begin
            build_large_genome();
            send_genome();
        end
        while (items_sent - start_items < PHASE_ITEMS)
        begin
            build_genome();
            send_genome();
        end
    endtask

    // Compare one popped result against the oldest predicted one.
    task automatic check_result();
        res_t want;
        results_taken++;
        if (pending_distances.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: result with none pending: distance %h mismatches %0d ovf %0b",
                         $realtime, distance, mismatches, overflowed);
        end
        else
        begin
            want = pending_distances.pop_front();
            if (distance !== want.distance || mismatches !== want.mismatches
                || overflowed !== want.overflowed)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result %0d: distance %h/%h mismatches %0d/%0d ovf %0b/%0b",
                             $realtime, results_taken, distance, want.distance,
                             mismatches, want.mismatches, overflowed, want.overflowed);
            end
        end
    endtask

    // Result side: random pops, one long hold-off so that the block backs up.
    initial
    begin : result_side
        int gap;
        bit steady;
        bit held;
        steady = 1'b0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                steady = ~steady;
            if (!held && results_taken == HOLD_AT_RESULT)
            begin
                gap = HOLD_CYCLES;
                held = 1'b1;
            end
            else
                gap = steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
            check_result();
        end
    end

    // Stall watchdog: any handshake on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (push && full === 1'b0) || (pop && empty === 1'b0)
            || (cfg_valid && cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Directed items, then random phases under a range of coefficient settings.
    initial
    begin : stimulus
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(CMD_COMPUTE,     16'd0,      32'h0000_0000, 1'b1, 48'h0, 10'd0);
        add_row(CMD_UNUSED,      16'hFFFF,   32'hFFFF_FFFF, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_FIRST,  16'd0,      32'h7FFF_FFFF, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_SECOND, 16'd0,      32'h8000_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_COMPUTE,     16'd0,      32'h0000_0000, 1'b1, 48'hFFFF_FFFF, 10'd0);
        add_row(CMD_LOAD_FIRST,  16'hFFFF,   32'h0000_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_SECOND, 16'd1,      32'hFFFF_FFFF, 1'b0, 48'h0, 10'd0);
        add_row(CMD_COMPUTE,     16'd0,      32'h0000_0000, 1'b1, 48'h2_0000, 10'd2);
        // Lists out of order.
        add_row(CMD_LOAD_FIRST,  16'd9,      32'h0001_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_FIRST,  16'd3,      32'h0002_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_SECOND, 16'd3,      32'hFFFF_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_SECOND, 16'd9,      32'h0001_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_COMPUTE,     16'd0,      32'h0000_0000, 1'b0, 48'h0, 10'd0);
        // Repeated innovation in one list.
        add_row(CMD_LOAD_FIRST,  16'd5,      32'h0000_0001, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_FIRST,  16'd5,      32'h0000_0002, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_SECOND, 16'd5,      32'h0000_8000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_COMPUTE,     16'd0,      32'h0000_0000, 1'b0, 48'h0, 10'd0);
        // Only the second list holds a link.
        add_row(CMD_LOAD_SECOND, 16'd100,    32'h1234_5678, 1'b0, 48'h0, 10'd0);
        add_row(CMD_COMPUTE,     16'd0,      32'h0000_0000, 1'b1, 48'h1_0000, 10'd1);
        // An ignored item in the middle of a genome changes nothing.
        add_row(CMD_LOAD_FIRST,  16'd7,      32'h0003_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_UNUSED,      16'd7,      32'h0005_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_LOAD_SECOND, 16'd7,      32'h0001_0000, 1'b0, 48'h0, 10'd0);
        add_row(CMD_COMPUTE,     16'd0,      32'h0000_0000, 1'b1, 48'h2_0000, 10'd0);

        for (k = 0; k < plan.size(); k++)
            send_item(plan[k].op, plan[k].innov, plan[k].weight, plan[k].fixed, plan[k].want);

        run_phase(1'b0);
        write_coeffs(16'h0000, 16'h0000);
        run_phase(1'b0);
        write_coeffs(16'hFFFF, 16'hFFFF);
        run_phase(1'b1);
        write_coeffs(16'h0001, 16'hFFFF);
        run_phase(1'b0);
        write_coeffs(16'hFFFF, 16'h0001);
        run_phase(1'b0);
        write_coeffs(COEFF_W'($urandom), COEFF_W'($urandom));
        run_phase(1'b0);
        write_coeffs(COEFF_RESET, 16'h0080);
        run_phase(1'b0);

        push <= 1'b0;
        while (pending_distances.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d link and compute items and %0d distances",
                 items_sent, results_taken);
        $display("over %0d coefficient settings; %0d carried the overflow flag.",
                 settings_used, overflow_results);
        $display("Largest mismatch count %0d; %0d errors.", deepest_mism, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ genome_compatibility_distance_top.f @@
sv/gcd_pkg.sv
sv/gcd_front.sv
sv/gcd_back.sv
sv/genome_compatibility_distance_top.sv
tb/genome_compatibility_distance_top_tb.sv
